>>> rtl/core/xxtea_pkg.sv
`default_nettype none

package xxtea_pkg;

	// Key schedule constant of the cipher.
	localparam logic [31:0] DELTA = 32'h9e3779b9;

	// Largest message the checker's word buffer holds.
	localparam int WORDS_LIMIT = 64;

	// Configuration register indexes.
	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_MODE = 3'd4;

	// One message beat.
	typedef struct packed {
		logic [31:0] data_word;
		logic        last_word;
	} msg_beat_t;

	// One result beat.
	typedef struct packed {
		logic [31:0] out_word;
		logic        out_last;
		logic        overflow;
	} res_beat_t;

	// One register write beat.
	typedef struct packed {
		logic [2:0]  reg_index;
		logic [31:0] wr_data;
	} cfg_beat_t;

	// Operands handed to the shared mix unit.
	typedef struct packed {
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] sum;
		logic [31:0] key;
	} mix_req_t;

	// Number of full rounds for an n-word message: 6 + 52/n, as a range table.
	// Messages longer than 52 words get the six base rounds only.
	function automatic logic [5:0] xxtea_rounds(input logic [6:0] n);
		logic [5:0] q;
		begin
			if (n >= 7'd53) begin
				q = 6'd0;
			end else if (n >= 7'd27) begin
				q = 6'd1;
			end else if (n >= 7'd18) begin
				q = 6'd2;
			end else if (n >= 7'd14) begin
				q = 6'd3;
			end else if (n >= 7'd11) begin
				q = 6'd4;
			end else if (n >= 7'd9) begin
				q = 6'd5;
			end else if (n == 7'd8) begin
				q = 6'd6;
			end else if (n == 7'd7) begin
				q = 6'd7;
			end else if (n == 7'd6) begin
				q = 6'd8;
			end else if (n == 7'd5) begin
				q = 6'd10;
			end else if (n == 7'd4) begin
				q = 6'd13;
			end else if (n == 7'd3) begin
				q = 6'd17;
			end else if (n == 7'd2) begin
				q = 6'd26;
			end else begin
				q = 6'd52;
			end
			return 6'd6 + q;
		end
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/xxtea_ifs.sv
`default_nettype none

// Message channel: one word per beat.
interface xxtea_msg_if;
	import xxtea_pkg::*;
	logic      valid;
	logic      ready;
	msg_beat_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// Result channel: one processed word per beat.
interface xxtea_res_if;
	import xxtea_pkg::*;
	logic      valid;
	logic      ready;
	res_beat_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// Register write channel.
interface xxtea_cfg_if;
	import xxtea_pkg::*;
	logic      valid;
	logic      ready;
	cfg_beat_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/xxtea_word_ram.sv
`default_nettype none

module xxtea_word_ram #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/xxtea_mix_unit.sv
`default_nettype none

module xxtea_mix_unit (
	input  logic                clk,
	input  logic                en,
	input  xxtea_pkg::mix_req_t req,
	output logic [31:0]         mx_q
);
	import xxtea_pkg::*;

	logic [31:0] shift_sum;
	logic [31:0] key_sum;

	// The two halves of the mix function run side by side.
	assign shift_sum = ((req.z >> 5) ^ (req.y << 2)) + ((req.y >> 3) ^ (req.z << 4));
	assign key_sum   = (req.sum ^ req.y) + (req.key ^ req.z);

	// Result is registered before the word update uses it.
	always_ff @(posedge clk) begin
		if (en) begin
			mx_q <= shift_sum ^ key_sum;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/xxtea_block_cipher.sv
// A message of n words is taken at one word per cycle while the block is idle. One
// word goes straight to output; longer ones run INIT_A, INIT_B and INIT_C, and
// alternate MIX and UPDATE for each word update through the single shared mix unit
// and the word buffer. Results leave one by one through OUT_RD and OUT_WAIT while
// the sink is ready. Reset (arst_n low, asynchronous) clears the sequencer, word
// count, overflow flag, key and mode registers; the word buffer is not cleared.
`default_nettype none

module xxtea_block_cipher #(
	parameter int MAX_WORDS = 64
) (
	input logic       clk,
	input logic       arst_n,
	xxtea_msg_if.sink msg,
	xxtea_res_if.source res,
	xxtea_cfg_if.sink cfg
);
	import xxtea_pkg::*;

	localparam int AW = $clog2(MAX_WORDS);
	localparam int CW = $clog2(MAX_WORDS + 1);
	localparam logic [AW-1:0] LAST_SLOT  = AW'(MAX_WORDS - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_WORDS);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_INIT_A   = 8'b0000_0010,
		S_INIT_B   = 8'b0000_0100,
		S_INIT_C   = 8'b0000_1000,
		S_MIX      = 8'b0001_0000,
		S_UPDATE   = 8'b0010_0000,
		S_OUT_RD   = 8'b0100_0000,
		S_OUT_WAIT = 8'b1000_0000
	} state_t;

	state_t        state_q;
	logic [31:0]   key_q [4];
	logic          dec_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [AW-1:0] last_q;
	logic [AW-1:0] p_q;
	logic [5:0]    rounds_q;
	logic          fwd_q;
	logic [31:0]   sum_q;
	logic [31:0]   cy_q;
	logic [31:0]   x_q;

	logic          msg_acc;
	logic          buf_full;
	logic [AW-1:0] slot;
	logic [31:0]   rd_data;
	logic [31:0]   nb;
	logic [31:0]   mx;
	logic [31:0]   v_new;
	logic [1:0]    p_low;
	logic [AW-1:0] p_next;
	logic [AW-1:0] rd_next;
	logic          round_end;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	mix_req_t      mix_req;

	// Next word index in the direction of travel, wrapping over the message.
	function automatic logic [AW-1:0] step_idx(input logic [AW-1:0] i,
			input logic [AW-1:0] last, input logic dec);
		logic [AW-1:0] r;
		begin
			if (dec) begin
				r = (i == '0) ? last : i - AW'(1);
			end else begin
				r = (i == last) ? '0 : i + AW'(1);
			end
			return r;
		end
	endfunction

	assign msg_acc  = msg.valid && msg.ready;
	assign buf_full = (count_q == FULL_COUNT);
	assign slot     = buf_full ? LAST_SLOT : count_q[AW-1:0];

	// Neighbor word: taken from the update just made when it was the one read.
	assign nb        = fwd_q ? cy_q : rd_data;
	assign p_low     = 2'(p_q);
	assign p_next    = step_idx(p_q, last_q, dec_q);
	assign rd_next   = step_idx(p_next, last_q, dec_q);
	assign round_end = dec_q ? (p_q == '0) : (p_q == last_q);
	assign v_new     = dec_q ? (x_q - mx) : (x_q + mx);

	// Operands of the mix function; y and z swap roles between directions.
	always_comb begin
		mix_req.y   = dec_q ? cy_q : nb;
		mix_req.z   = dec_q ? nb : cy_q;
		mix_req.sum = sum_q;
		mix_req.key = key_q[p_low ^ sum_q[3:2]];
	end

	// Buffer port control per sequencer state.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = p_q;
		ram_wdata = v_new;
		ram_re    = 1'b0;
		ram_raddr = p_q;
		case (state_q)
			S_IDLE: begin
				ram_we    = msg_acc && !buf_full;
				ram_waddr = count_q[AW-1:0];
				ram_wdata = msg.data.data_word;
			end
			S_INIT_A: begin
				ram_re    = 1'b1;
				ram_raddr = dec_q ? '0 : last_q;
			end
			S_INIT_B: begin
				ram_re    = 1'b1;
				ram_raddr = dec_q ? last_q : '0;
			end
			S_INIT_C: begin
				ram_re    = 1'b1;
				ram_raddr = dec_q ? (last_q - AW'(1)) : AW'(1);
			end
			S_UPDATE: begin
				ram_we    = 1'b1;
				ram_re    = 1'b1;
				ram_raddr = rd_next;
			end
			S_OUT_RD: begin
				ram_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	xxtea_word_ram #(
		.DEPTH(MAX_WORDS),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	xxtea_mix_unit u_mix (
		.clk(clk),
		.en(state_q == S_MIX),
		.req(mix_req),
		.mx_q(mx)
	);

	// Key and mode registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0] <= '0;
			key_q[1] <= '0;
			key_q[2] <= '0;
			key_q[3] <= '0;
			dec_q    <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.data.reg_index)
				REG_KEY0: key_q[0] <= cfg.data.wr_data;
				REG_KEY1: key_q[1] <= cfg.data.wr_data;
				REG_KEY2: key_q[2] <= cfg.data.wr_data;
				REG_KEY3: key_q[3] <= cfg.data.wr_data;
				REG_MODE: dec_q    <= cfg.data.wr_data[0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer: collect, set up, alternate mix and update, then stream out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			last_q   <= '0;
			p_q      <= '0;
			rounds_q <= '0;
			fwd_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (msg_acc) begin
						if (buf_full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
						if (msg.data.last_word) begin
							last_q   <= slot;
							rounds_q <= xxtea_rounds(7'(slot) + 7'd1);
							p_q      <= '0;
							state_q  <= (slot == '0) ? S_OUT_RD : S_INIT_A;
						end
					end
				end
				S_INIT_A: begin
					p_q     <= dec_q ? last_q : '0;
					state_q <= S_INIT_B;
				end
				S_INIT_B: begin
					state_q <= S_INIT_C;
				end
				S_INIT_C: begin
					fwd_q   <= 1'b0;
					state_q <= S_MIX;
				end
				S_MIX: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					p_q     <= p_next;
					fwd_q   <= (rd_next == p_q);
					state_q <= S_MIX;
					if (round_end) begin
						rounds_q <= rounds_q - 6'd1;
						if (rounds_q == 6'd1) begin
							p_q     <= '0;
							state_q <= S_OUT_RD;
						end
					end
				end
				S_OUT_RD: begin
					state_q <= S_OUT_WAIT;
				end
				S_OUT_WAIT: begin
					if (res.ready) begin
						if (p_q == last_q) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							p_q     <= p_q + AW'(1);
							state_q <= S_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working words and the running sum.
	always_ff @(posedge clk) begin
		case (state_q)
			S_INIT_A: begin
				sum_q <= dec_q ? (32'(rounds_q) * DELTA) : DELTA;
			end
			S_INIT_B: begin
				cy_q <= rd_data;
			end
			S_INIT_C: begin
				x_q <= rd_data;
			end
			S_UPDATE: begin
				cy_q <= v_new;
				x_q  <= nb;
				if (round_end) begin
					sum_q <= dec_q ? (sum_q - DELTA) : (sum_q + DELTA);
				end
			end
			default: begin
			end
		endcase
	end

	// Handshakes and result beat.
	assign msg.ready         = (state_q == S_IDLE);
	assign cfg.ready         = 1'b1;
	assign res.valid         = (state_q == S_OUT_WAIT);
	assign res.data.out_word = rd_data;
	assign res.data.out_last = (p_q == last_q);
	assign res.data.overflow = ovf_q;

endmodule

`default_nettype wire

>>> rtl/core/xxtea_checker.sv
`default_nettype none

module xxtea_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        msg_valid,
	input logic        msg_ready,
	input logic        msg_last,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_word,
	input logic        res_last,
	input logic        res_ovf,
	input logic        cfg_ready
);

	// No new message word is taken while a result beat is offered.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !msg_ready)
		else $error("message accepted while results are pending");

	// The final word of a message starts processing and closes the input.
	a_close_input: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_ready && msg_last |=> !msg_ready && !res_valid)
		else $error("input still open after the final word");

	// After the final result beat the output goes quiet.
	a_end_of_message: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res_last |=> !res_valid)
		else $error("result beat after the final word");

	// A stalled result beat holds its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_word)
			&& $stable(res_last) && $stable(res_ovf))
		else $error("stalled result beat changed");

	// Register writes are never stalled.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("register port not ready");

endmodule

bind xxtea_block_cipher xxtea_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.msg_valid(msg.valid),
	.msg_ready(msg.ready),
	.msg_last(msg.data.last_word),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_word(res.data.out_word),
	.res_last(res.data.out_last),
	.res_ovf(res.data.overflow),
	.cfg_ready(cfg.ready)
);

`default_nettype wire

>>> tb/sv/xxtea_result_checker.sv
module xxtea_result_checker #(
	parameter int MAX_WORDS = 64
) (
	input  logic  clk,
	input  logic  arst_n,
	xxtea_msg_if  msg,
	xxtea_res_if  res,
	xxtea_cfg_if  cfg,
	output int    fail_count,
	output int    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import xxtea_pkg::*;

	localparam int ROUNDS_BASE   = 6;
	localparam int ROUNDS_SPREAD = 52;

	// Shadow copy of the key and mode registers.
	logic [31:0] key_word [4];
	logic        decrypt_on;

	// Words of the message being collected.
	logic [31:0] held_word [MAX_WORDS];
	int          held_count;
	logic        words_dropped;

	// Cipher output words still owed by the block, oldest first.
	res_beat_t   cipher_words_due [$];
	int          mismatches;

	// One application of the XXTEA mix function.
	function automatic logic [31:0] mix_term(input logic [31:0] y, input logic [31:0] z,
			input logic [31:0] sum, input int p, input logic [1:0] e);
		logic [31:0] a;
		logic [31:0] b;
		logic [1:0]  sel;
		sel = 2'(p) ^ e;
		a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
		b = (sum ^ y) + (key_word[sel] ^ z);
		return a ^ b;
	endfunction

	// Encrypts the first n held words in place.
	function automatic void encipher_held(input int n);
		int          rounds;
		int          r;
		int          p;
		logic [31:0] sum;
		logic [31:0] y;
		logic [31:0] z;
		logic [1:0]  e;
		rounds = ROUNDS_BASE + ROUNDS_SPREAD / n;
		sum = '0;
		z = held_word[n - 1];
		for (r = 0; r < rounds; r++) begin
			sum = sum + DELTA;
			e = sum[3:2];
			for (p = 0; p < n - 1; p++) begin
				y = held_word[p + 1];
				held_word[p] = held_word[p] + mix_term(y, z, sum, p, e);
				z = held_word[p];
			end
			y = held_word[0];
			held_word[n - 1] = held_word[n - 1] + mix_term(y, z, sum, n - 1, e);
			z = held_word[n - 1];
		end
	endfunction

	// Decrypts the first n held words in place.
	function automatic void decipher_held(input int n);
		int          rounds;
		int          r;
		int          p;
		logic [31:0] sum;
		logic [31:0] y;
		logic [31:0] z;
		logic [1:0]  e;
		rounds = ROUNDS_BASE + ROUNDS_SPREAD / n;
		sum = 32'(rounds) * DELTA;
		y = held_word[0];
		for (r = 0; r < rounds; r++) begin
			e = sum[3:2];
			for (p = n - 1; p > 0; p--) begin
				z = held_word[p - 1];
				held_word[p] = held_word[p] - mix_term(y, z, sum, p, e);
				y = held_word[p];
			end
			z = held_word[n - 1];
			held_word[0] = held_word[0] - mix_term(y, z, sum, 0, e);
			y = held_word[0];
			sum = sum - DELTA;
		end
	endfunction

	// Reports one field that differs and returns the number of errors found.
	function automatic int field_errors(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got === want) begin
			return 0;
		end
		$display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
		return 1;
	endfunction

	// Watch all three channels, predict on each message end, compare each result beat.
	always @(posedge clk or negedge arst_n) begin : watch
		res_beat_t got;
		res_beat_t want;
		int        k;
		if (!arst_n) begin
			key_word      = '{default: '0};
			decrypt_on    = 1'b0;
			held_count    = 0;
			words_dropped = 1'b0;
			mismatches    = 0;
			cipher_words_due.delete();
		end else begin
			// Register writes; indexes past the mode register are ignored.
			if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
				case (cfg.data.reg_index)
					REG_KEY0: key_word[0] = cfg.data.wr_data;
					REG_KEY1: key_word[1] = cfg.data.wr_data;
					REG_KEY2: key_word[2] = cfg.data.wr_data;
					REG_KEY3: key_word[3] = cfg.data.wr_data;
					REG_MODE: decrypt_on = cfg.data.wr_data[0];
					default: ;
				endcase
			end

			// Message beats: store while there is room, otherwise note the drop.
			if (msg.valid === 1'b1 && msg.ready === 1'b1) begin
				if (held_count < MAX_WORDS) begin
					held_word[held_count] = msg.data.data_word;
					held_count++;
				end else begin
					words_dropped = 1'b1;
				end
				if (msg.data.last_word) begin
					// A single word passes through untouched.
					if (held_count > 1) begin
						if (decrypt_on) begin
							decipher_held(held_count);
						end else begin
							encipher_held(held_count);
						end
					end
					for (k = 0; k < held_count; k++) begin
						want.out_word = held_word[k];
						want.out_last = (k == held_count - 1);
						want.overflow = words_dropped;
						cipher_words_due.push_back(want);
					end
					held_count    = 0;
					words_dropped = 1'b0;
				end
			end

			// Result beats against the oldest prediction.
			if (res.valid === 1'b1 && res.ready === 1'b1) begin
				got = res.data;
				if (cipher_words_due.size() == 0) begin
					$display("%0t ns: result beat with nothing expected, got word %h last %b overflow %b",
						$time, got.out_word, got.out_last, got.overflow);
					mismatches++;
				end else begin
					want = cipher_words_due.pop_front();
					mismatches += field_errors("out_word", want.out_word, got.out_word);
					mismatches += field_errors("out_last", 32'(want.out_last), 32'(got.out_last));
					mismatches += field_errors("overflow", 32'(want.overflow), 32'(got.overflow));
				end
			end
		end
		fail_count  <= mismatches;
		outstanding <= cipher_words_due.size();
	end

endmodule

>>> tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import xxtea_pkg::*;

	localparam int         SETTLE_CYCLES = 8;
	localparam int         LONG_HOLD     = 300;
	localparam int         TIME_LIMIT_NS = 4_000_000;
	localparam logic [2:0] REG_SPARE_LO  = REG_MODE + 3'd1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   outstanding;
	int   words_sent = 0;
	bit   idle_enable = 1'b1;
	bit   hold_results = 1'b0;

	xxtea_msg_if msg_ch ();
	xxtea_res_if res_ch ();
	xxtea_cfg_if cfg_ch ();

	xxtea_block_cipher u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	xxtea_result_checker #(
		.MAX_WORDS (WORDS_LIMIT)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.msg         (msg_ch),
		.res         (res_ch),
		.cfg         (cfg_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result side: random stall bursts, plus one long hold-off on request.
	initial begin : result_sink
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_results) begin
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_results = 1'b0;
				res_ch.ready <= 1'b1;
			end else if (idle_enable && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Offers one message word, sometimes after an idle burst, and waits for the beat.
	// Valid stays high afterwards, so back-to-back beats keep it asserted.
	task automatic send_word(input logic [31:0] word, input logic is_last);
		msg_beat_t beat;
		beat.data_word = word;
		beat.last_word = is_last;
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			msg_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		msg_ch.valid <= 1'b1;
		msg_ch.data  <= beat;
		do @(posedge clk); while (msg_ch.ready !== 1'b1);
		words_sent++;
	endtask

	// Biased toward all-zero and all-one words.
	function automatic logic [31:0] pick_word();
		logic [31:0] word;
		case ($urandom_range(0, 7))
			0: word = '0;
			1: word = '1;
			default: word = $urandom;
		endcase
		return word;
	endfunction

	// Mostly short messages, now and then a longer one.
	function automatic int short_length();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			return $urandom_range(1, 6);
		end else if (pick < 9) begin
			return $urandom_range(7, 16);
		end
		return $urandom_range(17, 40);
	endfunction

	task automatic send_message(input int length);
		int i;
		for (i = 0; i < length; i++) begin
			send_word(pick_word(), i == length - 1);
		end
	endtask

	task automatic fill_to(input int target);
		while (words_sent < target) begin
			send_message(short_length());
		end
	endtask

	// Stops offering words and waits for every predicted result plus a settle time.
	task automatic drain();
		msg_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [2:0] index, input logic [31:0] value);
		cfg_beat_t beat;
		beat.reg_index = index;
		beat.wr_data   = value;
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= beat;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
	endtask

	// Writes the whole key and the mode, plus one write to an unused index.
	task automatic load_settings(input logic [31:0] k0, input logic [31:0] k1,
			input logic [31:0] k2, input logic [31:0] k3, input logic decrypt);
		logic [31:0] noise;
		noise = $urandom;
		write_cfg(REG_KEY0, k0);
		write_cfg(REG_KEY1, k1);
		write_cfg(REG_KEY2, k2);
		write_cfg(REG_KEY3, k3);
		write_cfg(REG_SPARE_LO + 3'($urandom_range(0, 2)), noise);
		write_cfg(REG_MODE, {noise[31:1], decrypt});
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : stimulus
		msg_ch.valid <= 1'b0;
		msg_ch.data  <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero key, encrypt; single words pass through, then short messages.
		load_settings('0, '0, '0, '0, 1'b0);
		send_word(32'h0000_0000, 1'b1);
		send_word(32'hffff_ffff, 1'b1);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'hffff_ffff, 1'b1);
		send_word(32'hffff_ffff, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h8000_0001, 1'b1);
		drain();

		// Directed: all-ones key, decrypt.
		load_settings('1, '1, '1, '1, 1'b1);
		send_word(32'hffff_ffff, 1'b0);
		send_word(32'hffff_ffff, 1'b1);
		send_word(32'h0000_0000, 1'b1);
		repeat (4) send_word(32'h0000_0000, 1'b0);
		send_word(32'h0000_0000, 1'b1);
		drain();

		// Encrypt with a random key; one message fills the buffer exactly.
		load_settings($urandom, $urandom, $urandom, $urandom, 1'b0);
		send_message(WORDS_LIMIT);
		fill_to(110);
		drain();

		// Decrypt while the result side holds off long enough to back up the input.
		load_settings($urandom, $urandom, $urandom, $urandom, 1'b1);
		hold_results = 1'b1;
		repeat (6) send_message($urandom_range(4, 8));
		drain();

		// No idling; an oversized message loses its tail words.
		idle_enable = 1'b0;
		load_settings('1, '0, '1, '0, 1'b0);
		send_message(WORDS_LIMIT + 2);
		fill_to(235);
		drain();

		// Random key, decrypt, with idling back on.
		idle_enable = 1'b1;
		load_settings($urandom, $urandom, $urandom, $urandom, 1'b1);
		fill_to(270);
		drain();

		// Final stretch at full rate in a random direction.
		idle_enable = 1'b0;
		load_settings($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
		fill_to(305);
		drain();

		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin : watchdog
		#(TIME_LIMIT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
